// File: hw/rtl/compacting_value_list_assert.svh
// Assertion macros for the checker file of the compacting value list.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef COMPACTING_VALUE_LIST_ASSERT_SVH
`define COMPACTING_VALUE_LIST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CVL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("compacting_value_list: assertion failed");

// next-cycle implication, disabled during reset
`define CVL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("compacting_value_list: assertion failed");

`endif

// File: hw/rtl/cvl_pkg.sv
// Package for the compacting value list: command and status codes, result type.
// No dependencies.
package cvl_pkg;

  localparam int KIND_W   = 3;
  localparam int STAT_W   = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 56;

  localparam logic [KIND_W-1:0] K_APPEND    = 3'd0;
  localparam logic [KIND_W-1:0] K_DELETE    = 3'd1;
  localparam logic [KIND_W-1:0] K_SEARCH    = 3'd2;
  localparam logic [KIND_W-1:0] K_OVERWRITE = 3'd3;
  localparam logic [KIND_W-1:0] K_DUMP      = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        entry_index;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } cvl_res_t;

  function automatic cvl_res_t mk_res(input logic [STAT_W-1:0] status,
                                      input logic [POS_W-1:0] fpos,
                                      input logic [VAL_W-1:0] val,
                                      input logic [POS_W-1:0] idx,
                                      input logic [COUNT_W-1:0] cnt,
                                      input logic last);
    cvl_res_t r;
    r.status         = status;
    r.found_position = fpos;
    r.entry_value    = val;
    r.entry_index    = idx;
    r.count          = cnt;
    r.last           = last;
    return r;
  endfunction

endpackage

// File: hw/rtl/cvl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/cvl_ctrl.sv
// Command sequencer of the compacting value list: scan, shift and dump loops
// over the entry RAM, plus the entry count. Depends on cvl_pkg.
module cvl_ctrl import cvl_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [VAL_W-1:0]    in_value,
  input  logic [POS_W-1:0]    in_position,
  input  logic                out_free,
  output logic                push,
  output cvl_res_t            res,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [VAL_W-1:0]    ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [VAL_W-1:0]    ram_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_W-1:0] CAP7 = COUNT_W'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DUMP  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  cvl_res_t          res_r, res_nxt;

  logic [COUNT_W-1:0] count7, idx7, nxt1, nxt2;
  logic               match;

  // read address that stays inside the RAM; out-of-range reads are never used
  function automatic logic [AW-1:0] safe_addr(input logic [COUNT_W-1:0] a);
    return (a < CAP7) ? AW'(a) : '0;
  endfunction

  assign count7 = COUNT_W'(count_r);
  assign idx7   = COUNT_W'(idx_r);
  assign nxt1   = idx7 + COUNT_W'(1);
  assign nxt2   = idx7 + COUNT_W'(2);
  assign match  = (ram_rdata == value_r);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    push      = 1'b0;
    res       = res_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          value_nxt = in_value;
          idx_nxt   = '0;
          state_nxt = S_EMIT;
          res_nxt   = mk_res(ST_DONE, '0, '0, '0, '0, 1'b1);
          case (in_kind) inside
            K_APPEND: begin
              if (count7 >= CAP7) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            K_DELETE, K_SEARCH: begin
              if (count_r == '0) begin
                res_nxt.status = ST_NOTFOUND;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            K_OVERWRITE: begin
              if (COUNT_W'(in_position) >= count7) begin
                res_nxt.status = ST_BADPOS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_position);
                ram_wdata = in_value;
              end
            end
            K_DUMP: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // entry idx is on the read port; fetch idx+1 ahead
        ram_re    = 1'b1;
        ram_raddr = safe_addr(nxt1);
        if (match) begin
          if (kind_r == K_SEARCH) begin
            res_nxt   = mk_res(ST_DONE, POS_W'(idx_r), '0, '0, '0, 1'b1);
            state_nxt = S_EMIT;
          end else if (nxt1 < count7) begin
            state_nxt = S_SHIFT;
          end else begin
            count_nxt = count_r - CW'(1);
            res_nxt   = mk_res(ST_DONE, '0, '0, '0, '0, 1'b1);
            state_nxt = S_EMIT;
          end
        end else if (nxt1 >= count7) begin
          res_nxt   = mk_res(ST_NOTFOUND, '0, '0, '0, '0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = AW'(nxt1);
        end
      end

      S_SHIFT: begin
        // entry idx+1 is on the read port: move it down, fetch idx+2
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = safe_addr(nxt2);
        if (nxt2 < count7) begin
          idx_nxt = AW'(nxt1);
        end else begin
          count_nxt = count_r - CW'(1);
          res_nxt   = mk_res(ST_DONE, '0, '0, '0, '0, 1'b1);
          state_nxt = S_EMIT;
        end
      end

      S_DUMP: begin
        // read data holds while the output is stalled
        res = mk_res(ST_ENTRY, '0, ram_rdata, POS_W'(idx_r), count7, nxt1 == count7);
        if (out_free) begin
          push = 1'b1;
          if (nxt1 == count7) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = safe_addr(nxt1);
            idx_nxt   = AW'(nxt1);
          end
        end
      end

      S_EMIT: begin
        res       = res_r;
        res.count = count7;
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      kind_r  <= K_APPEND;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    res_r   <= res_nxt;
  end

endmodule

// File: hw/rtl/compacting_value_list.sv
// Compacting value list: an ordered list of signed 32-bit values kept in a
// CAPACITY-entry RAM with an entry count, driven by one command per input
// item (append, delete first match with compaction, search, overwrite at a
// position, dump all). Commands run one at a time; in_tready is high only
// while the sequencer is idle. Every entry access goes through the single
// read port and single write port of the entry RAM, one entry per cycle
// (a dump waits while out_tready holds the output register full). Append,
// overwrite and unknown kinds need no RAM loop; search scans the entries up
// to the first match; delete scans to the match, then moves each later entry
// down by one; dump reads every entry in order. Each also waits on out_tready. A
// one-item output register sits between the sequencer and out_*, so a new
// command is taken while the previous result still waits on the output.
// Append to a full list answers "list full" and stores nothing. Of the list,
// only the count is reset; entries are read only below the count, so the RAM
// needs no clearing.
// Depends on cvl_pkg, cvl_ram, cvl_ctrl.
module compacting_value_list import cvl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [31:0] value, [37:32] position, rest zero
  input  logic [KIND_W-1:0] in_tuser,   // [2:0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [5:0] found_position, [37:6] entry_value,
                                        // [43:38] entry_index, [50:44] count, rest zero
  output logic [STAT_W-1:0] out_tuser,  // [2:0] status
  output logic              out_tlast   // last result of the command
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              out_free;
  logic              push;
  cvl_res_t          res;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  // output stage
  logic     out_valid_r;
  cvl_res_t out_res_r;

  assign out_free = !out_valid_r || out_tready;

  cvl_ctrl #(.CAPACITY(CAPACITY), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_value   (in_tdata[VAL_W-1:0]),
    .in_position(in_tdata[VAL_W+POS_W-1:VAL_W]),
    .out_free   (out_free),
    .push       (push),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // entry store
  cvl_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY), .AW(AW)) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {5'b0, out_res_r.count, out_res_r.entry_index,
                       out_res_r.entry_value, out_res_r.found_position};

endmodule

// File: hw/rtl/cvl_checker.sv
// Port-level checks for the compacting value list, bound to the top level.
// Depends on cvl_pkg and compacting_value_list_assert.svh.
`include "compacting_value_list_assert.svh"

module cvl_checker import cvl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_DW-1:0]  in_tdata,
  input logic [KIND_W-1:0] in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [STAT_W-1:0] out_tuser,
  input logic              out_tlast
);

  // a stalled result holds
  `CVL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // count never passes the capacity
  `CVL_ASSERT_IMP(a_count_cap, out_tvalid, out_tdata[50:44] <= COUNT_W'(CAPACITY))

  // only dump entries may come without last
  `CVL_ASSERT_IMP(a_single_last, out_tvalid && out_tuser != ST_ENTRY, out_tlast)

  // a dumped index lies below the count
  `CVL_ASSERT_IMP(a_dump_index, out_tvalid && out_tuser == ST_ENTRY, out_tdata[43:38] < 6'(out_tdata[50:44]) || out_tdata[50:44] == 7'd64)

endmodule

bind compacting_value_list cvl_checker #(.CAPACITY(CAPACITY)) u_cvl_checker (.*);
